@@ rtl/fpes_pkg.sv @@
// Package for the flash program/erase sequencer.
// Holds widths, flash command and status codes, and the types used by the
// sequencer modules. Depends on nothing.
package fpes_pkg;

   localparam int ADDR_WIDTH    = 24;
   localparam int DATA_WIDTH    = 16;
   localparam int TIMEOUT_WIDTH = 24;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [TIMEOUT_WIDTH-1:0] TIMEOUT_RESET = TIMEOUT_WIDTH'(1000);

   // Input item codes.
   localparam logic [2:0] CMD_PROGRAM = 3'd0;
   localparam logic [2:0] CMD_SUSPEND = 3'd1;
   localparam logic [2:0] CMD_RESUME  = 3'd2;
   localparam logic [2:0] CMD_READ    = 3'd3;
   localparam logic [2:0] CMD_TICK    = 3'd4;

   // Result kinds.
   localparam logic [1:0] KIND_WRITE = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_DONE  = 2'd2;

   // Completion status codes.
   localparam logic [3:0] ST_OK        = 4'd0;
   localparam logic [3:0] ST_TIMEOUT   = 4'd1;
   localparam logic [3:0] ST_VPP       = 4'd2;
   localparam logic [3:0] ST_PROGRAM   = 4'd3;
   localparam logic [3:0] ST_PROTECTED = 4'd4;
   localparam logic [3:0] ST_UNKNOWN   = 4'd5;
   localparam logic [3:0] ST_READBACK  = 4'd6;
   localparam logic [3:0] ST_SUSPENDED = 4'd7;
   localparam logic [3:0] ST_BUSY      = 4'd8;

   // Flash command words.
   localparam logic [DATA_WIDTH-1:0] FCMD_PROGRAM     = DATA_WIDTH'(8'h40);
   localparam logic [DATA_WIDTH-1:0] FCMD_READ_ARRAY  = DATA_WIDTH'(8'hFF);
   localparam logic [DATA_WIDTH-1:0] FCMD_READ_STATUS = DATA_WIDTH'(8'h70);
   localparam logic [DATA_WIDTH-1:0] FCMD_SUSPEND     = DATA_WIDTH'(8'hB0);
   localparam logic [DATA_WIDTH-1:0] FCMD_RESUME      = DATA_WIDTH'(8'hD0);

   // Status register bit positions and the clean ready word.
   localparam int SB_READY     = 7;
   localparam int SB_SUSPENDED = 6;
   localparam int SB_PROG_ERR  = 4;
   localparam int SB_VPP_ERR   = 3;
   localparam int SB_PROT_ERR  = 1;
   localparam logic [DATA_WIDTH-1:0] STATUS_CLEAN = DATA_WIDTH'(8'h80);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_PROG_POLL,
      PH_VERIFY,
      PH_SUSP_POLL,
      PH_RESUME
   } phase_type;

   // Bus sequences the back end knows how to play out.
   typedef enum logic [2:0] {
      OP_PROG_START,   // write 0x40, write data, read status
      OP_SUSP_START,   // write 0xB0, write 0x70, read status
      OP_RES_START,    // write 0x70, read status
      OP_POLL_READ,    // read status again
      OP_VERIFY_READ,  // read back the programmed word
      OP_ARRAY_DONE,   // write 0xFF, then done
      OP_RESUME_DONE,  // write 0xD0, then done ok
      OP_DONE          // done only
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [ADDR_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0] value;
      logic [3:0]            status;
   } desc_type;

endpackage

@@ rtl/flash_program_erase_sequencer_top.sv @@
// Top level of the flash program/erase sequencer.
// Depends on fpes_pkg, fpes_front, fpes_queue and fpes_back.
//
// The sequencer drives a command-set flash over a result stream of bus
// writes, bus reads and completion items; read data and timer ticks come back
// in as request items. The front end takes one item per cycle while the
// two-entry descriptor queue has room, and the back end delivers one result
// per cycle while the receiver is ready, so an item's cost is the number of
// results it causes: three for a program or suspend request that starts an
// operation, two for a resume, one for a request refused as busy, one or two
// for a returned bus word, and none for a bus word that arrives while idle or
// for most ticks; the back end's single result port limits the flow. The
// first result of an item passes the queue, the back end's descriptor register
// and its output register before it is presented. Requests that arrive while
// an operation is open are answered with a busy completion and change nothing.
module flash_program_erase_sequencer_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [2:0]                          req_cmd,
   input  logic [fpes_pkg::ADDR_WIDTH-1:0]     req_address,
   input  logic [fpes_pkg::DATA_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_kind,
   output logic [fpes_pkg::ADDR_WIDTH-1:0]     rsp_bus_address,
   output logic [fpes_pkg::DATA_WIDTH-1:0]     rsp_bus_value,
   output logic [3:0]                          rsp_done_status,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpes_pkg::TIMEOUT_WIDTH-1:0]  csr_timeout_ticks
);

   logic               push, q_full, q_pop, q_valid;
   fpes_pkg::desc_type push_desc, q_desc;

   assign req_ready = !q_full;

   fpes_front u_front (
      .clock             (clock),
      .reset             (reset),
      .item_fire         (req_valid && req_ready),
      .item_cmd          (req_cmd),
      .item_address      (req_address),
      .item_value        (req_value),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ticks (csr_timeout_ticks),
      .push              (push),
      .push_desc         (push_desc)
   );

   fpes_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_desc  (q_desc)
   );

   fpes_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_desc          (q_desc),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_bus_address (rsp_bus_address),
      .rsp_bus_value   (rsp_bus_value),
      .rsp_done_status (rsp_done_status),
      .rsp_last        (rsp_last)
   );

endmodule

@@ rtl/fpes_front.sv @@
// Front end of the flash sequencer: accepts items, tracks the operation phase
// and the timeout, and turns each item into a bus sequence descriptor.
// Depends on fpes_pkg.
module fpes_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                item_fire,
   input  logic [2:0]                          item_cmd,
   input  logic [fpes_pkg::ADDR_WIDTH-1:0]     item_address,
   input  logic [fpes_pkg::DATA_WIDTH-1:0]     item_value,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fpes_pkg::TIMEOUT_WIDTH-1:0]  csr_timeout_ticks,
   output logic                                push,
   output fpes_pkg::desc_type                  push_desc
);

   fpes_pkg::phase_type                   phase_ff, phase_in;
   logic [fpes_pkg::TIMEOUT_WIDTH-1:0]    elapsed_ff, elapsed_in;
   logic [fpes_pkg::TIMEOUT_WIDTH-1:0]    timeout_ff, timeout_in;
   logic [fpes_pkg::ADDR_WIDTH-1:0]       held_address_ff, held_address_in;
   logic [fpes_pkg::DATA_WIDTH-1:0]       held_value_ff, held_value_in;
   logic [fpes_pkg::TIMEOUT_WIDTH-1:0]    elapsed_inc;
   logic                                  is_request;

   function automatic logic [3:0] decode_error(input logic [fpes_pkg::DATA_WIDTH-1:0] s);
      logic [3:0] code;
      if (s[fpes_pkg::SB_VPP_ERR])       code = fpes_pkg::ST_VPP;
      else if (s[fpes_pkg::SB_PROG_ERR]) code = fpes_pkg::ST_PROGRAM;
      else if (s[fpes_pkg::SB_PROT_ERR]) code = fpes_pkg::ST_PROTECTED;
      else                               code = fpes_pkg::ST_UNKNOWN;
      return code;
   endfunction

   assign csr_ready  = 1'b1;
   assign is_request = (item_cmd <= fpes_pkg::CMD_RESUME);

   // Saturating tick count.
   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= fpes_pkg::PH_IDLE;
         elapsed_ff <= '0;
         timeout_ff <= fpes_pkg::TIMEOUT_RESET;
      end else begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         timeout_ff <= timeout_in;
      end
   end

   always_ff @(posedge clock) begin
      held_address_ff <= held_address_in;
      held_value_ff   <= held_value_in;
   end

   always_comb begin
      phase_in          = phase_ff;
      elapsed_in        = elapsed_ff;
      timeout_in        = (csr_valid && csr_ready) ? csr_timeout_ticks : timeout_ff;
      held_address_in   = held_address_ff;
      held_value_in     = held_value_ff;
      push              = 1'b0;
      push_desc.op      = fpes_pkg::OP_DONE;
      push_desc.address = '0;
      push_desc.value   = '0;
      push_desc.status  = fpes_pkg::ST_OK;

      if (item_fire) begin
         if (is_request && phase_ff != fpes_pkg::PH_IDLE) begin
            push             = 1'b1;
            push_desc.status = fpes_pkg::ST_BUSY;
         end else begin
            unique case (item_cmd)
               fpes_pkg::CMD_PROGRAM: begin
                  held_address_in   = item_address;
                  held_value_in     = item_value;
                  elapsed_in        = '0;
                  phase_in          = fpes_pkg::PH_PROG_POLL;
                  push              = 1'b1;
                  push_desc.op      = fpes_pkg::OP_PROG_START;
                  push_desc.address = item_address;
                  push_desc.value   = item_value;
               end
               fpes_pkg::CMD_SUSPEND: begin
                  elapsed_in   = '0;
                  phase_in     = fpes_pkg::PH_SUSP_POLL;
                  push         = 1'b1;
                  push_desc.op = fpes_pkg::OP_SUSP_START;
               end
               fpes_pkg::CMD_RESUME: begin
                  phase_in     = fpes_pkg::PH_RESUME;
                  push         = 1'b1;
                  push_desc.op = fpes_pkg::OP_RES_START;
               end
               fpes_pkg::CMD_READ: begin
                  unique case (phase_ff)
                     fpes_pkg::PH_PROG_POLL: begin
                        push = 1'b1;
                        if (!item_value[fpes_pkg::SB_READY]) begin
                           push_desc.op = fpes_pkg::OP_POLL_READ;
                        end else if (item_value != fpes_pkg::STATUS_CLEAN) begin
                           phase_in         = fpes_pkg::PH_IDLE;
                           push_desc.op     = fpes_pkg::OP_ARRAY_DONE;
                           push_desc.status = decode_error(item_value);
                        end else begin
                           phase_in          = fpes_pkg::PH_VERIFY;
                           push_desc.op      = fpes_pkg::OP_VERIFY_READ;
                           push_desc.address = held_address_ff;
                        end
                     end
                     fpes_pkg::PH_VERIFY: begin
                        phase_in         = fpes_pkg::PH_IDLE;
                        push             = 1'b1;
                        push_desc.status = (item_value == held_value_ff) ?
                                           fpes_pkg::ST_OK : fpes_pkg::ST_READBACK;
                     end
                     fpes_pkg::PH_SUSP_POLL: begin
                        push = 1'b1;
                        if (!item_value[fpes_pkg::SB_READY]) begin
                           push_desc.op = fpes_pkg::OP_POLL_READ;
                        end else begin
                           phase_in         = fpes_pkg::PH_IDLE;
                           push_desc.op     = fpes_pkg::OP_ARRAY_DONE;
                           push_desc.status = item_value[fpes_pkg::SB_SUSPENDED] ?
                                              fpes_pkg::ST_SUSPENDED : fpes_pkg::ST_OK;
                        end
                     end
                     fpes_pkg::PH_RESUME: begin
                        phase_in     = fpes_pkg::PH_IDLE;
                        push         = 1'b1;
                        push_desc.op = item_value[fpes_pkg::SB_SUSPENDED] ?
                                       fpes_pkg::OP_RESUME_DONE : fpes_pkg::OP_DONE;
                     end
                     default: ;
                  endcase
               end
               fpes_pkg::CMD_TICK: begin
                  if (phase_ff == fpes_pkg::PH_PROG_POLL ||
                      phase_ff == fpes_pkg::PH_SUSP_POLL) begin
                     elapsed_in = elapsed_inc;
                     if (elapsed_inc >= timeout_ff) begin
                        phase_in         = fpes_pkg::PH_IDLE;
                        push             = 1'b1;
                        push_desc.status = fpes_pkg::ST_TIMEOUT;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
   end

endmodule

@@ rtl/fpes_queue.sv @@
// Short descriptor queue between the sequencer's front and back ends.
// Depends on fpes_pkg.
module fpes_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  fpes_pkg::desc_type push_desc,
   output logic               full,
   input  logic               pop,
   output logic               pop_valid,
   output fpes_pkg::desc_type pop_desc
);

   localparam int PtrWidth = (fpes_pkg::QUEUE_DEPTH > 1) ? $clog2(fpes_pkg::QUEUE_DEPTH) : 1;
   localparam int CntWidth = $clog2(fpes_pkg::QUEUE_DEPTH + 1);

   fpes_pkg::desc_type        slot_ff [fpes_pkg::QUEUE_DEPTH];
   logic [PtrWidth-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]       count_ff, count_in;
   logic                      do_push, do_pop;

   function automatic logic [PtrWidth-1:0] next_ptr(input logic [PtrWidth-1:0] p);
      logic [PtrWidth-1:0] r;
      if (p == PtrWidth'(fpes_pkg::QUEUE_DEPTH - 1)) r = '0;
      else                                          r = p + 1'b1;
      return r;
   endfunction

   assign full      = (count_ff == CntWidth'(fpes_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_desc  = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)      count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_desc;
   end

endmodule

@@ rtl/fpes_back.sv @@
// Back end of the flash sequencer: plays out one descriptor as a series of bus
// write, bus read and done results, one per cycle while the receiver is ready,
// through an output register. Depends on fpes_pkg.
module fpes_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   input  fpes_pkg::desc_type              q_desc,
   output logic                            q_pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [1:0]                      rsp_kind,
   output logic [fpes_pkg::ADDR_WIDTH-1:0] rsp_bus_address,
   output logic [fpes_pkg::DATA_WIDTH-1:0] rsp_bus_value,
   output logic [3:0]                      rsp_done_status,
   output logic                            rsp_last
);

   fpes_pkg::desc_type              cur_ff, cur_in;
   logic                            cur_valid_ff, cur_valid_in;
   logic [1:0]                      step_ff, step_in;
   logic                            out_valid_ff, out_valid_in;
   logic [1:0]                      kind_ff, kind_in;
   logic [fpes_pkg::ADDR_WIDTH-1:0] address_ff, address_in;
   logic [fpes_pkg::DATA_WIDTH-1:0] value_ff, value_in;
   logic [3:0]                      status_ff, status_in;
   logic                            last_ff, last_in;

   logic [1:0]                      gen_kind;
   logic [fpes_pkg::ADDR_WIDTH-1:0] gen_address;
   logic [fpes_pkg::DATA_WIDTH-1:0] gen_value;
   logic [3:0]                      gen_status;
   logic                            gen_last;
   logic                            emit, cur_done;

   // Result for the current descriptor at the current step.
   always_comb begin
      gen_kind    = fpes_pkg::KIND_READ;
      gen_address = '0;
      gen_value   = '0;
      gen_status  = fpes_pkg::ST_OK;
      gen_last    = 1'b0;
      unique case (cur_ff.op)
         fpes_pkg::OP_PROG_START: begin
            if (step_ff == 2'd0) begin
               gen_kind  = fpes_pkg::KIND_WRITE;
               gen_value = fpes_pkg::FCMD_PROGRAM;
            end else if (step_ff == 2'd1) begin
               gen_kind    = fpes_pkg::KIND_WRITE;
               gen_address = cur_ff.address;
               gen_value   = cur_ff.value;
            end else begin
               gen_last = 1'b1;
            end
         end
         fpes_pkg::OP_SUSP_START: begin
            if (step_ff == 2'd0) begin
               gen_kind  = fpes_pkg::KIND_WRITE;
               gen_value = fpes_pkg::FCMD_SUSPEND;
            end else if (step_ff == 2'd1) begin
               gen_kind  = fpes_pkg::KIND_WRITE;
               gen_value = fpes_pkg::FCMD_READ_STATUS;
            end else begin
               gen_last = 1'b1;
            end
         end
         fpes_pkg::OP_RES_START: begin
            if (step_ff == 2'd0) begin
               gen_kind  = fpes_pkg::KIND_WRITE;
               gen_value = fpes_pkg::FCMD_READ_STATUS;
            end else begin
               gen_last = 1'b1;
            end
         end
         fpes_pkg::OP_POLL_READ: begin
            gen_last = 1'b1;
         end
         fpes_pkg::OP_VERIFY_READ: begin
            gen_address = cur_ff.address;
            gen_last    = 1'b1;
         end
         fpes_pkg::OP_ARRAY_DONE: begin
            if (step_ff == 2'd0) begin
               gen_kind  = fpes_pkg::KIND_WRITE;
               gen_value = fpes_pkg::FCMD_READ_ARRAY;
            end else begin
               gen_kind   = fpes_pkg::KIND_DONE;
               gen_status = cur_ff.status;
               gen_last   = 1'b1;
            end
         end
         fpes_pkg::OP_RESUME_DONE: begin
            if (step_ff == 2'd0) begin
               gen_kind  = fpes_pkg::KIND_WRITE;
               gen_value = fpes_pkg::FCMD_RESUME;
            end else begin
               gen_kind = fpes_pkg::KIND_DONE;
               gen_last = 1'b1;
            end
         end
         fpes_pkg::OP_DONE: begin
            gen_kind   = fpes_pkg::KIND_DONE;
            gen_status = cur_ff.status;
            gen_last   = 1'b1;
         end
         default: ;
      endcase
   end

   assign emit     = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign cur_done = emit && gen_last;
   assign q_pop    = q_valid && (!cur_valid_ff || cur_done);

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (q_pop) begin
         cur_in       = q_desc;
         cur_valid_in = 1'b1;
         step_in      = '0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end

      out_valid_in = out_valid_ff;
      kind_in      = kind_ff;
      address_in   = address_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      last_in      = last_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         kind_in      = gen_kind;
         address_in   = gen_address;
         value_in     = gen_value;
         status_in    = gen_status;
         last_in      = gen_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      kind_ff    <= kind_in;
      address_ff <= address_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
      last_ff    <= last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_bus_address = address_ff;
   assign rsp_bus_value   = value_ff;
   assign rsp_done_status = status_ff;
   assign rsp_last        = last_ff;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for flash_program_erase_sequencer_top, with random idling.
// Depends on fpes_pkg and the sequencer RTL. Results are checked against a behavioral
// model of the command sequencer that is kept inside this file.
module testbench;
   import fpes_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   // Idle margin that wait_for_drain adds once every expected result has been taken.
   localparam int SETTLE_CYCLES = 12;
   localparam int PRINT_LIMIT   = 40;

   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;

   localparam logic [DATA_WIDTH-1:0] BIT_READY     = DATA_WIDTH'(1) << SB_READY;
   localparam logic [DATA_WIDTH-1:0] BIT_SUSPENDED = DATA_WIDTH'(1) << SB_SUSPENDED;
   localparam logic [DATA_WIDTH-1:0] BIT_PROG_ERR  = DATA_WIDTH'(1) << SB_PROG_ERR;
   localparam logic [DATA_WIDTH-1:0] BIT_VPP_ERR   = DATA_WIDTH'(1) << SB_VPP_ERR;
   localparam logic [DATA_WIDTH-1:0] BIT_PROT_ERR  = DATA_WIDTH'(1) << SB_PROT_ERR;

   typedef struct packed {
      logic [1:0]            kind;
      logic [ADDR_WIDTH-1:0] address;
      logic [DATA_WIDTH-1:0] value;
      logic [3:0]            status;
      logic                  last;
   } bus_result_type;

   typedef enum {READY_STEADY, READY_RANDOM, READY_SPARSE} ready_mode_type;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic [2:0]               req_cmd           = CMD_TICK;
   logic [ADDR_WIDTH-1:0]    req_address       = '0;
   logic [DATA_WIDTH-1:0]    req_value         = '0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic [1:0]               rsp_kind;
   logic [ADDR_WIDTH-1:0]    rsp_bus_address;
   logic [DATA_WIDTH-1:0]    rsp_bus_value;
   logic [3:0]               rsp_done_status;
   logic                     rsp_last;
   logic                     csr_valid         = 1'b0;
   logic                     csr_ready;
   logic [TIMEOUT_WIDTH-1:0] csr_timeout_ticks = '0;

   // Sequencer state as this testbench tracks it.
   phase_type                seq_phase     = PH_IDLE;
   logic [TIMEOUT_WIDTH-1:0] poll_ticks    = '0;
   logic [TIMEOUT_WIDTH-1:0] timeout_limit = TIMEOUT_RESET;
   logic [ADDR_WIDTH-1:0]    prog_address  = '0;
   logic [DATA_WIDTH-1:0]    prog_word     = '0;
   bus_result_type           bus_results_due[$];

   int             error_count      = 0;
   int             items_sent       = 0;
   int             results_checked  = 0;
   int             cycle_count      = 0;
   int             burst_left       = 0;
   int             rsp_hold_request = 0;
   int             hold_left        = 0;
   int             mode_left        = 0;
   int             ready_beat       = 0;
   ready_mode_type ready_mode       = READY_STEADY;

   flash_program_erase_sequencer_top u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_address       (req_address),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_bus_address   (rsp_bus_address),
      .rsp_bus_value     (rsp_bus_value),
      .rsp_done_status   (rsp_done_status),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_timeout_ticks (csr_timeout_ticks)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bus_result_type bus_op(input logic [1:0] kind,
                                             input logic [ADDR_WIDTH-1:0] address,
                                             input logic [DATA_WIDTH-1:0] value,
                                             input logic [3:0] status);
      return {kind, address, value, status, 1'b0};
   endfunction

   // Advances the tracked sequencer by one accepted item and queues the bus results it causes.
   function automatic void step_flash_sequencer(input logic [2:0] cmd,
                                                input logic [ADDR_WIDTH-1:0] address,
                                                input logic [DATA_WIDTH-1:0] value);
      bus_result_type batch[$];
      logic [3:0]     err;
      if (cmd <= CMD_RESUME && seq_phase != PH_IDLE) begin
         batch.push_back(bus_op(KIND_DONE, '0, '0, ST_BUSY));
      end else begin
         case (cmd)
            CMD_PROGRAM: begin
               prog_address = address;
               prog_word    = value;
               poll_ticks   = '0;
               seq_phase    = PH_PROG_POLL;
               batch.push_back(bus_op(KIND_WRITE, '0, FCMD_PROGRAM, ST_OK));
               batch.push_back(bus_op(KIND_WRITE, address, value, ST_OK));
               batch.push_back(bus_op(KIND_READ, '0, '0, ST_OK));
            end
            CMD_SUSPEND: begin
               poll_ticks = '0;
               seq_phase  = PH_SUSP_POLL;
               batch.push_back(bus_op(KIND_WRITE, '0, FCMD_SUSPEND, ST_OK));
               batch.push_back(bus_op(KIND_WRITE, '0, FCMD_READ_STATUS, ST_OK));
               batch.push_back(bus_op(KIND_READ, '0, '0, ST_OK));
            end
            CMD_RESUME: begin
               seq_phase = PH_RESUME;
               batch.push_back(bus_op(KIND_WRITE, '0, FCMD_READ_STATUS, ST_OK));
               batch.push_back(bus_op(KIND_READ, '0, '0, ST_OK));
            end
            CMD_READ: begin
               case (seq_phase)
                  PH_PROG_POLL: begin
                     if (!value[SB_READY]) begin
                        batch.push_back(bus_op(KIND_READ, '0, '0, ST_OK));
                     end else if (value != STATUS_CLEAN) begin
                        // Error bits are decoded in priority order: Vpp, program, protection.
                        if (value[SB_VPP_ERR])       err = ST_VPP;
                        else if (value[SB_PROG_ERR]) err = ST_PROGRAM;
                        else if (value[SB_PROT_ERR]) err = ST_PROTECTED;
                        else                         err = ST_UNKNOWN;
                        seq_phase = PH_IDLE;
                        batch.push_back(bus_op(KIND_WRITE, '0, FCMD_READ_ARRAY, ST_OK));
                        batch.push_back(bus_op(KIND_DONE, '0, '0, err));
                     end else begin
                        seq_phase = PH_VERIFY;
                        batch.push_back(bus_op(KIND_READ, prog_address, '0, ST_OK));
                     end
                  end
                  PH_VERIFY: begin
                     seq_phase = PH_IDLE;
                     batch.push_back(bus_op(KIND_DONE, '0, '0,
                                            (value == prog_word) ? ST_OK : ST_READBACK));
                  end
                  PH_SUSP_POLL: begin
                     if (!value[SB_READY]) begin
                        batch.push_back(bus_op(KIND_READ, '0, '0, ST_OK));
                     end else begin
                        seq_phase = PH_IDLE;
                        batch.push_back(bus_op(KIND_WRITE, '0, FCMD_READ_ARRAY, ST_OK));
                        batch.push_back(bus_op(KIND_DONE, '0, '0,
                                               value[SB_SUSPENDED] ? ST_SUSPENDED : ST_OK));
                     end
                  end
                  PH_RESUME: begin
                     seq_phase = PH_IDLE;
                     if (value[SB_SUSPENDED])
                        batch.push_back(bus_op(KIND_WRITE, '0, FCMD_RESUME, ST_OK));
                     batch.push_back(bus_op(KIND_DONE, '0, '0, ST_OK));
                  end
                  default: ;
               endcase
            end
            CMD_TICK: begin
               if (seq_phase == PH_PROG_POLL || seq_phase == PH_SUSP_POLL) begin
                  if (poll_ticks != '1) poll_ticks++;
                  if (poll_ticks >= timeout_limit) begin
                     seq_phase = PH_IDLE;
                     batch.push_back(bus_op(KIND_DONE, '0, '0, ST_TIMEOUT));
                  end
               end
            end
            default: ;
         endcase
      end
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[i]) bus_results_due.push_back(batch[i]);
   endfunction

   task automatic report_mismatch(input string msg);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("ERROR cycle %0d result %0d: %s", cycle_count, results_checked, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
   endtask

   // Offers one item and holds it until accepted. Valid stays high inside a burst, so the
   // next item follows without a gap; a random gap ends each burst.
   task automatic send_item(input logic [2:0] cmd, input logic [ADDR_WIDTH-1:0] address,
                            input logic [DATA_WIDTH-1:0] value);
      req_valid   <= 1'b1;
      req_cmd     <= cmd;
      req_address <= address;
      req_value   <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      step_flash_sequencer(cmd, address, value);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40) : $urandom_range(0, 6);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (bus_results_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_WIDTH-1:0] ticks);
      wait_for_drain();
      csr_valid         <= 1'b1;
      csr_timeout_ticks <= ticks;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      timeout_limit = ticks;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Answers whatever operation is still open with words that finish it cleanly.
   task automatic close_operation();
      while (seq_phase != PH_IDLE)
         send_item(CMD_READ, '0, (seq_phase == PH_VERIFY) ? prog_word : STATUS_CLEAN);
   endtask

   task automatic test_program_paths();
      // Clean program at the bottom of the array, with one busy poll and a tick during verify.
      send_item(CMD_PROGRAM, '0, '0);
      send_item(CMD_READ, '0, '0);
      send_item(CMD_READ, '0, STATUS_CLEAN);
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_READ, '1, '0);
      // An all-ones status carries every error bit, so Vpp must win.
      send_item(CMD_PROGRAM, '1, '1);
      send_item(CMD_READ, '1, '1);
      send_item(CMD_PROGRAM, 24'h5A5A5A, 16'hA5A5);
      send_item(CMD_READ, '0, STATUS_CLEAN | BIT_PROG_ERR | BIT_PROT_ERR);
      send_item(CMD_PROGRAM, 24'hA5A5A5, 16'h5A5A);
      send_item(CMD_READ, '0, STATUS_CLEAN | BIT_PROT_ERR);
      send_item(CMD_PROGRAM, 24'h800001, 16'h8001);
      send_item(CMD_READ, '0, ~(BIT_VPP_ERR | BIT_PROG_ERR | BIT_PROT_ERR));
      // Read-back mismatch, with a request refused as busy while verifying.
      send_item(CMD_PROGRAM, 24'h123456, 16'hBEEF);
      send_item(CMD_READ, '0, STATUS_CLEAN);
      send_item(CMD_SUSPEND, '0, '0);
      send_item(CMD_READ, '0, 16'hBEEE);
   endtask

   task automatic test_erase_suspend_resume();
      send_item(CMD_SUSPEND, '1, '1);
      send_item(CMD_READ, '0, BIT_SUSPENDED);
      send_item(CMD_RESUME, '0, '0);
      send_item(CMD_READ, '0, BIT_READY | BIT_SUSPENDED);
      send_item(CMD_RESUME, '1, '1);
      send_item(CMD_TICK, '0, '0);
      send_item(CMD_READ, '0, BIT_SUSPENDED);
      send_item(CMD_SUSPEND, '0, '0);
      send_item(CMD_READ, '0, STATUS_CLEAN);
      send_item(CMD_RESUME, '0, '0);
      send_item(CMD_READ, '0, ~BIT_SUSPENDED);
   endtask

   task automatic test_ignored_items();
      send_item(CMD_READ, '1, '1);
      send_item(CMD_TICK, '1, '1);
      for (int k = 0; k < 3; k++)
         send_item(CMD_UNUSED_FIRST + 3'(k), ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
   endtask

   task automatic test_poll_timeout();
      // A zero limit expires on the very first tick.
      write_timeout('0);
      send_item(CMD_SUSPEND, '0, '0);
      send_item(CMD_TICK, '0, '0);
      write_timeout(TIMEOUT_WIDTH'(1));
      send_item(CMD_PROGRAM, 24'h00F00F, 16'h0FF0);
      send_item(CMD_READ, '0, '0);
      send_item(CMD_TICK, '0, '0);
      // The reply to the poll that was cut short now arrives while idle.
      send_item(CMD_READ, '0, STATUS_CLEAN);
   endtask

   task automatic test_backpressure();
      write_timeout(TIMEOUT_RESET);
      rsp_hold_request = 80;
      burst_left       = 40;
      send_item(CMD_PROGRAM, 24'h3C3C3C, 16'hC3C3);
      send_item(CMD_SUSPEND, '0, '0);
      send_item(CMD_RESUME, '0, '0);
      send_item(CMD_PROGRAM, '1, '1);
      send_item(CMD_READ, '0, '0);
      send_item(CMD_READ, '0, STATUS_CLEAN);
      send_item(CMD_READ, '0, 16'hC3C3);
      wait_for_drain();
   endtask

   // Random operations played out with random status words, ticks, busy requests and noise.
   task automatic run_flash_sessions(input int item_budget);
      int                    stop_at;
      int                    steps;
      logic [DATA_WIDTH-1:0] reply;
      stop_at = items_sent + item_budget;
      while (items_sent < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_item(CMD_PROGRAM, ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
            4, 5: send_item(CMD_SUSPEND, ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
            6: send_item(CMD_RESUME, ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
            default: send_item(3'($urandom), ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
         endcase
         steps = 0;
         while (seq_phase != PH_IDLE && steps < 12) begin
            steps++;
            reply = DATA_WIDTH'($urandom);
            case (seq_phase)
               PH_PROG_POLL, PH_SUSP_POLL: begin
                  case ($urandom_range(0, 5))
                     0, 1: reply[SB_READY] = 1'b0;
                     2: reply = STATUS_CLEAN;
                     default: reply[SB_READY] = 1'b1;
                  endcase
               end
               PH_VERIFY: if ($urandom_range(0, 3) != 0) reply = prog_word;
               default: ;
            endcase
            case ($urandom_range(0, 9))
               0, 1: send_item(CMD_TICK, ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
               2: send_item(CMD_PROGRAM + 3'($urandom_range(0, 2)), ADDR_WIDTH'($urandom),
                            DATA_WIDTH'($urandom));
               default: send_item(CMD_READ, ADDR_WIDTH'($urandom), reply);
            endcase
         end
         close_operation();
         // A late status word; after a timeout it lands on an idle sequencer.
         if ($urandom_range(0, 4) == 0)
            send_item(CMD_READ, ADDR_WIDTH'($urandom), DATA_WIDTH'($urandom));
      end
   endtask

   task automatic test_random_settings();
      run_flash_sessions(10);
      write_timeout('1);
      run_flash_sessions(10);
      write_timeout(TIMEOUT_WIDTH'(1));
      run_flash_sessions(10);
      write_timeout(TIMEOUT_WIDTH'($urandom_range(2, 12)));
      run_flash_sessions(12);
      write_timeout('0);
      run_flash_sessions(8);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_program_paths();
      test_erase_suspend_resume();
      test_ignored_items();
      test_poll_timeout();
      test_backpressure();
      test_random_settings();
      wait_for_drain();
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Result receiver: a long hold-off when asked for, otherwise changing stall patterns.
   always @(posedge clock) begin
      if (rsp_hold_request > 0) begin
         hold_left        = rsp_hold_request;
         rsp_hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            mode_left  = $urandom_range(4, 40);
         end
         mode_left--;
         ready_beat++;
         case (ready_mode)
            READY_STEADY: rsp_ready <= 1'b1;
            READY_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
            default:      rsp_ready <= (ready_beat % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      bus_result_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (bus_results_due.size() == 0) begin
            report_mismatch($sformatf("unexpected kind %0d address %h value %h status %0d",
                                      rsp_kind, rsp_bus_address, rsp_bus_value,
                                      rsp_done_status));
         end else begin
            due = bus_results_due.pop_front();
            check_field("kind", 32'(rsp_kind), 32'(due.kind));
            check_field("bus_address", 32'(rsp_bus_address), 32'(due.address));
            check_field("bus_value", 32'(rsp_bus_value), 32'(due.value));
            check_field("done_status", 32'(rsp_done_status), 32'(due.status));
            check_field("last", 32'(rsp_last), 32'(due.last));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

endmodule

@@ filelist.f @@
rtl/fpes_pkg.sv
rtl/fpes_front.sv
rtl/fpes_queue.sv
rtl/fpes_back.sv
rtl/flash_program_erase_sequencer_top.sv
dv/testbench.sv
